// File: hw/rtl/ip_range_to_octet_blocks_defines.svh
// ----------------------------------------------------------------------------
// ip_range_to_octet_blocks_defines
// Assertion macros shared by the range splitter RTL.
// ----------------------------------------------------------------------------
`ifndef IP_RANGE_TO_OCTET_BLOCKS_DEFINES_SVH
`define IP_RANGE_TO_OCTET_BLOCKS_DEFINES_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define IPROB_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("iprob assertion failed");

// cons must hold in the same cycle whenever ante holds
`define IPROB_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iprob assertion failed");

`else

`define IPROB_ASSERT_ALWAYS(label, cond)
`define IPROB_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

// File: hw/rtl/iprob_pkg.sv
// ----------------------------------------------------------------------------
// iprob_pkg
// Types and constants of the IPv4 range to octet block splitter.
// ----------------------------------------------------------------------------
package iprob_pkg;

	localparam int unsigned NumSlots = 7;
	localparam int unsigned AddrW    = 3;

	// register word index, taken from paddr[2]
	localparam logic RegMaxRange = 1'b0;

	typedef enum logic [1:0] {
		ST_RUN       = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_REVERSED  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LVL_32 = 2'd0,
		LVL_24 = 2'd1,
		LVL_16 = 2'd2,
		LVL_8  = 2'd3
	} level_t;

	typedef struct packed {
		level_t      level;
		logic [31:0] start;
		logic [8:0]  count;
	} run_t;

	typedef struct packed {
		logic [31:0]               a;
		logic [31:0]               b;
		logic [15:0]               tag;
		logic                      excl;
		status_t                   status;
		logic                      done;
		logic [NumSlots-1:0]       mask;
		run_t [NumSlots-1:0]       runs;
	} item_t;

endpackage

// File: hw/rtl/iprob_in_if.sv
// ----------------------------------------------------------------------------
// iprob_in_if
// Range channel: one parsed IPv4 range per beat.
// ----------------------------------------------------------------------------
interface iprob_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_address;
	logic [31:0] last_address;
	logic [15:0] value_tag;
	logic        excluded;

	modport source (
		output valid, first_address, last_address, value_tag, excluded,
		input  ready
	);

	modport sink (
		input  valid, first_address, last_address, value_tag, excluded,
		output ready
	);
endinterface

// File: hw/rtl/iprob_out_if.sv
// ----------------------------------------------------------------------------
// iprob_out_if
// Result channel: one block run or rejection per beat.
// ----------------------------------------------------------------------------
interface iprob_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  level;
	logic [31:0] block_start;
	logic [8:0]  block_count;
	logic [15:0] tag_out;
	logic        excluded_out;
	logic        last;

	modport source (
		output valid, status, level, block_start, block_count, tag_out,
			excluded_out, last,
		input  ready
	);

	modport sink (
		input  valid, status, level, block_start, block_count, tag_out,
			excluded_out, last,
		output ready
	);
endinterface

// File: hw/rtl/iprob_octet_stage.sv
// ----------------------------------------------------------------------------
// iprob_octet_stage
// One registered octet stage: splits off the partial low and high runs, or
// closes the item when the remaining range fits one block.
// ----------------------------------------------------------------------------
module iprob_octet_stage #(
	parameter int unsigned Stage = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                prev_valid,
	input  iprob_pkg::item_t    prev_item,
	output logic                valid_q,
	output iprob_pkg::item_t    item_q
);

	localparam int unsigned Sh = 8 * Stage;
	localparam int unsigned Lo = 2 * Stage;
	localparam int unsigned Hi = 2 * Stage + 1;

	iprob_pkg::item_t nxt;
	logic [31:0]      a;
	logic [31:0]      b;
	logic [31:0]      diff;
	logic [31:0]      span_cnt;
	logic             whole;

	assign a        = prev_item.a;
	assign b        = prev_item.b;
	assign diff     = b - a;
	assign span_cnt = diff + 32'd1;
	assign whole    = (a | 32'd255) >= b;

	always_comb begin
		nxt = prev_item;
		if (!prev_item.done) begin
			if (whole) begin
				nxt.done = 1'b1;
				nxt.runs[Lo].start = a << Sh;
				if (diff == 32'd255) begin
					// one whole block: promote a level
					nxt.runs[Lo].level = iprob_pkg::level_t'(2'(Stage + 1));
					nxt.runs[Lo].count = 9'd1;
					nxt.mask[Lo]       = 1'b1;
				end else begin
					nxt.runs[Lo].level = iprob_pkg::level_t'(2'(Stage));
					nxt.runs[Lo].count = span_cnt[8:0];
					nxt.mask[Lo]       = span_cnt != 32'd0;
				end
			end else begin
				if (a[7:0] != 8'd0) begin
					nxt.runs[Lo].level = iprob_pkg::level_t'(2'(Stage));
					nxt.runs[Lo].start = a << Sh;
					nxt.runs[Lo].count = 9'd256 - {1'b0, a[7:0]};
					nxt.mask[Lo]       = 1'b1;
					nxt.a              = (a >> 8) + 32'd1;
				end else begin
					nxt.a = a >> 8;
				end
				if (b[7:0] != 8'd255) begin
					nxt.runs[Hi].level = iprob_pkg::level_t'(2'(Stage));
					nxt.runs[Hi].start = (b & ~32'd255) << Sh;
					nxt.runs[Hi].count = {1'b0, b[7:0]} + 9'd1;
					nxt.mask[Hi]       = 1'b1;
					nxt.b              = (b >> 8) - 32'd1;
				end else begin
					nxt.b = b >> 8;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule

// File: hw/rtl/ip_range_to_octet_blocks.sv
// ----------------------------------------------------------------------------
// ip_range_to_octet_blocks
// Splits an IPv4 range into runs of /32, /24, /16 and /8 blocks, or rejects
// it as reversed or too large.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  item_in   in   first_address, last_address, value_tag, excluded
//  run_out   out  status, level, block_start, block_count, tag_out,
//                 excluded_out, last
//  apb       in   max_range register at word 0
//
// Five register stages (checks, three octet stages, /8 run) feed an output
// register. One range per cycle unless the output stalls the pipe; a range
// with n runs gives n result beats.
// Reset clears valid bits, the output run mask and max_range.
// All stages advance together; a stall at the output freezes the pipe.
// ----------------------------------------------------------------------------
`include "ip_range_to_octet_blocks_defines.svh"

module ip_range_to_octet_blocks (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iprob_pkg::AddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	iprob_in_if.sink                      item_in,
	iprob_out_if.source                   run_out
);

	localparam int unsigned NumSlots = iprob_pkg::NumSlots;
	localparam int unsigned RunW     = $bits(iprob_pkg::run_t);

	logic [31:0] max_range_q;

	logic en;

	iprob_pkg::item_t item_in_c;
	iprob_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	iprob_pkg::item_t item_fin_c;
	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [31:0] span;
	logic [31:0] fin_cnt;

	logic [NumSlots-1:0]          mask_q;
	iprob_pkg::run_t [NumSlots-1:0] runs_q;
	iprob_pkg::status_t           status_q;
	logic [15:0]                  tag_q;
	logic                         excl_q;

	logic [NumSlots-1:0] lowest;
	logic [NumSlots-1:0] rest;
	logic [RunW-1:0]     sel_bits;
	iprob_pkg::run_t     sel_run;
	logic                out_last;
	logic                take;
	logic                load;

	// config port
	assign pready = 1'b1;
	assign prdata = max_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == iprob_pkg::RegMaxRange) begin
			max_range_q <= pwdata;
		end
	end

	// stage 1: range checks
	assign span = item_in.last_address - item_in.first_address;

	always_comb begin
		item_in_c        = '0;
		item_in_c.a      = item_in.first_address;
		item_in_c.b      = item_in.last_address;
		item_in_c.tag    = item_in.value_tag;
		item_in_c.excl   = item_in.excluded;
		item_in_c.status = iprob_pkg::ST_RUN;
		if (item_in.first_address > item_in.last_address) begin
			item_in_c.status = iprob_pkg::ST_REVERSED;
		end else if (max_range_q != 32'd0 && span >= max_range_q) begin
			item_in_c.status = iprob_pkg::ST_TOO_LARGE;
		end
		if (item_in_c.status != iprob_pkg::ST_RUN) begin
			// rejection: single zero run in slot 0
			item_in_c.done    = 1'b1;
			item_in_c.mask[0] = 1'b1;
		end
	end

	assign item_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in_c;
		end
	end

	// stages 2..4: octet stages
	iprob_octet_stage #(.Stage(0)) u_oct0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.prev_valid (valid_s1),
		.prev_item  (item_s1),
		.valid_q    (valid_s2),
		.item_q     (item_s2)
	);

	iprob_octet_stage #(.Stage(1)) u_oct1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.prev_valid (valid_s2),
		.prev_item  (item_s2),
		.valid_q    (valid_s3),
		.item_q     (item_s3)
	);

	iprob_octet_stage #(.Stage(2)) u_oct2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.prev_valid (valid_s3),
		.prev_item  (item_s3),
		.valid_q    (valid_s4),
		.item_q     (item_s4)
	);

	// stage 5: closing /8 run
	assign fin_cnt = item_s4.b - item_s4.a + 32'd1;

	always_comb begin
		item_fin_c = item_s4;
		if (!item_s4.done) begin
			item_fin_c.runs[NumSlots-1].level = iprob_pkg::LVL_8;
			item_fin_c.runs[NumSlots-1].start = item_s4.a << 24;
			item_fin_c.runs[NumSlots-1].count = fin_cnt[8:0];
			item_fin_c.mask[NumSlots-1]       = fin_cnt != 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5 <= item_fin_c;
		end
	end

	// output register: drains one run per beat, lowest slot first
	assign lowest   = mask_q & (~mask_q + NumSlots'(1));
	assign rest     = mask_q & (mask_q - NumSlots'(1));
	assign out_last = rest == '0;
	assign take     = run_out.valid && run_out.ready;
	assign load     = valid_s5 && (!run_out.valid || (take && out_last));
	assign en       = !valid_s5 || load;

	always_comb begin
		sel_bits = '0;
		for (int i = 0; i < NumSlots; i++) begin
			sel_bits = sel_bits | (runs_q[i] & {RunW{lowest[i]}});
		end
	end

	assign sel_run = iprob_pkg::run_t'(sel_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= item_s5.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			runs_q   <= item_s5.runs;
			status_q <= item_s5.status;
			tag_q    <= item_s5.tag;
			excl_q   <= item_s5.excl;
		end
	end

	assign run_out.valid        = |mask_q;
	assign run_out.status       = status_q;
	assign run_out.level        = sel_run.level;
	assign run_out.block_start  = sel_run.start;
	assign run_out.block_count  = sel_run.count;
	assign run_out.tag_out      = tag_q;
	assign run_out.excluded_out = excl_q;
	assign run_out.last         = out_last;

	// checks
	`IPROB_ASSERT_IMPLIES(a_stall_needs_s5, !item_in.ready, valid_s5)
	`IPROB_ASSERT_IMPLIES(a_reject_single, |mask_q && status_q != iprob_pkg::ST_RUN, out_last)
	`IPROB_ASSERT_IMPLIES(a_reject_count, |mask_q && status_q != iprob_pkg::ST_RUN, ~|sel_run.count)
	`IPROB_ASSERT_IMPLIES(a_run_nonempty, |mask_q && status_q == iprob_pkg::ST_RUN, |sel_run.count)

endmodule

// File: verif/ip_range_to_octet_blocks_tb.sv
// ----------------------------------------------------------------------------
// ip_range_to_octet_blocks_tb
// Drives IPv4 ranges into the splitter and predicts every block run or
// rejection. A scoreboard checks each result beat in order, field by field.
// The max_range register is set between phases through the APB port.
// ----------------------------------------------------------------------------
import iprob_pkg::*;

class octet_run_checker;
	typedef struct packed {
		status_t     status;
		level_t      level;
		logic [31:0] start;
		logic [8:0]  count;
		logic [15:0] tag;
		logic        excl;
		logic        last;
	} block_run_t;

	block_run_t  awaited_runs[$];
	logic [31:0] max_range;
	int          mismatch_count;
	int          produced;

	function new();
		max_range = '0;
		mismatch_count = 0;
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			mismatch_count++;
		end
	endfunction

	function void add_run(level_t lvl, logic [31:0] start, logic [31:0] count,
			logic [15:0] tag, logic excl);
		block_run_t r;
		if (count == 0 || produced >= NumSlots)
			return;
		r.status = ST_RUN;
		r.level  = lvl;
		r.start  = start;
		r.count  = count[8:0];
		r.tag    = tag;
		r.excl   = excl;
		r.last   = 1'b0;
		awaited_runs.push_back(r);
		produced++;
	endfunction

	// low and high partial runs per octet; a whole block goes one level up
	function void split_range(logic [31:0] a, logic [31:0] b, logic [15:0] tag, logic excl);
		int stage;
		int sh;
		for (stage = 0; stage < 3; stage++) begin
			sh = stage * 8;
			if ((a | 32'd255) >= b) begin
				if (b - a == 32'd255)
					add_run(level_t'(stage + 1), a << sh, 32'd1, tag, excl);
				else
					add_run(level_t'(stage), a << sh, b - a + 32'd1, tag, excl);
				return;
			end
			if (a[7:0] != 8'h00) begin
				add_run(level_t'(stage), a << sh, 32'd256 - 32'(a[7:0]), tag, excl);
				a = (a >> 8) + 32'd1;
			end else begin
				a = a >> 8;
			end
			if (b[7:0] != 8'hFF) begin
				add_run(level_t'(stage), {b[31:8], 8'h00} << sh,
					32'(b[7:0]) + 32'd1, tag, excl);
				b = (b >> 8) - 32'd1;
			end else begin
				b = b >> 8;
			end
		end
		add_run(LVL_8, a << 24, b - a + 32'd1, tag, excl);
	endfunction

	function void note_range(logic [31:0] a, logic [31:0] b, logic [15:0] tag, logic excl);
		block_run_t r;
		produced = 0;
		if (a > b || (max_range != 0 && b - a >= max_range)) begin
			if (a > b)
				r.status = ST_REVERSED;
			else
				r.status = ST_TOO_LARGE;
			r.level = LVL_32;
			r.start = '0;
			r.count = '0;
			r.tag   = tag;
			r.excl  = excl;
			r.last  = 1'b1;
			awaited_runs.push_back(r);
			return;
		end
		split_range(a, b, tag, excl);
		if (produced > 0) begin
			r = awaited_runs.pop_back();
			r.last = 1'b1;
			awaited_runs.push_back(r);
		end
	endfunction

	function void check_run(logic [1:0] status, logic [1:0] level, logic [31:0] start,
			logic [8:0] count, logic [15:0] tag, logic excl, logic last);
		block_run_t want;
		if (awaited_runs.size() == 0) begin
			$error("unexpected run beat: status %0d start %0h count %0d", status, start, count);
			mismatch_count++;
			return;
		end
		want = awaited_runs.pop_front();
		compare_field("status", 32'(want.status), 32'(status));
		compare_field("level", 32'(want.level), 32'(level));
		compare_field("block_start", want.start, start);
		compare_field("block_count", 32'(want.count), 32'(count));
		compare_field("tag_out", 32'(want.tag), 32'(tag));
		compare_field("excluded_out", 32'(want.excl), 32'(excl));
		compare_field("last", 32'(want.last), 32'(last));
	endfunction
endclass

module ip_range_to_octet_blocks_tb;
	localparam logic [AddrW-1:0] MaxRangeAddr = {RegMaxRange, 2'b00};
	localparam logic [AddrW-1:0] SpareAddr    = {~RegMaxRange, 2'b00};
	localparam int HoldCycles  = 300;
	localparam int DrainCycles = 12;
	localparam int StallLimit  = 2000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	bit idle_on   = 1'b1;
	bit hold_req  = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;

	octet_run_checker sb = new();

	iprob_in_if  range_ch ();
	iprob_out_if run_ch ();

	ip_range_to_octet_blocks dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item_in (range_ch),
		.run_out (run_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && range_ch.valid && range_ch.ready)
			sb.note_range(range_ch.first_address, range_ch.last_address,
				range_ch.value_tag, range_ch.excluded);
		if (arst_n && run_ch.valid && run_ch.ready)
			sb.check_run(run_ch.status, run_ch.level, run_ch.block_start, run_ch.block_count,
				run_ch.tag_out, run_ch.excluded_out, run_ch.last);
	end

	always @(posedge clk) begin
		if ((range_ch.valid && range_ch.ready) || (run_ch.valid && run_ch.ready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result sink: random stalls, plus a long hold-off on request
	initial begin
		run_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				run_ch.ready <= 1'b0;
			end else begin
				run_ch.ready <= !(idle_on && $urandom_range(99) < 8);
			end
		end
	end

	task write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == MaxRangeAddr)
			sb.max_range = data;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task read_max_range;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= MaxRangeAddr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.compare_field("max_range", sb.max_range, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// leaves valid high after the accepting edge
	task send_range(input logic [31:0] a, input logic [31:0] b, input logic [15:0] tag,
			input logic excl);
		while (idle_on && $urandom_range(99) < 8) begin
			range_ch.valid <= 1'b0;
			@(posedge clk);
		end
		range_ch.valid         <= 1'b1;
		range_ch.first_address <= a;
		range_ch.last_address  <= b;
		range_ch.value_tag     <= tag;
		range_ch.excluded      <= excl;
		do @(posedge clk); while (!range_ch.ready);
	endtask

	task settle;
		range_ch.valid <= 1'b0;
		while (sb.awaited_runs.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task send_random_ranges(input int n);
		logic [31:0] a;
		logic [31:0] b;
		int kind;
		int k;
		repeat (n) begin
			kind = $urandom_range(99);
			a = $urandom();
			if (kind < 6) begin
				if (a == 0)
					a = 32'd1;
				b = $urandom_range(a - 32'd1, 0);
			end else if (kind < 12) begin
				b = a;
			end else if (kind < 32) begin
				k = 8 * $urandom_range(3, 1);
				a = a & ~((32'd1 << k) - 32'd1);
				b = a | ((32'd1 << k) - 32'd1);
			end else begin
				b = a + ($urandom() >> $urandom_range(31, 0));
				if (b < a)
					b = 32'hFFFF_FFFF;
				// octet-aligned edges drive the promotion paths
				for (k = 0; k < 3; k++) begin
					if ($urandom_range(2) == 0)
						a[8*k +: 8] = 8'h00;
					if ($urandom_range(2) == 0)
						b[8*k +: 8] = 8'hFF;
				end
			end
			send_range(a, b, 16'($urandom()), 1'($urandom()));
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		range_ch.valid         <= 1'b0;
		range_ch.first_address <= '0;
		range_ch.last_address  <= '0;
		range_ch.value_tag     <= '0;
		range_ch.excluded      <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_max_range();

		// span check off
		send_range(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_range(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_range(32'h0000_0001, 32'h0000_0000, 16'h1234, 1'b0);
		send_range(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b1);
		send_range(32'h0A01_0200, 32'h0A01_02FF, 16'h0001, 1'b0);
		send_range(32'h0A01_0000, 32'h0A01_FFFF, 16'h8000, 1'b1);
		send_range(32'h0A00_0000, 32'h0AFF_FFFF, 16'h7FFF, 1'b0);
		send_range(32'h0102_0304, 32'hC864_3219, 16'hA5A5, 1'b1);
		send_range(32'h0A00_00FF, 32'h0A00_0100, 16'h5A5A, 1'b0);
		send_range(32'h01FF_0000, 32'h0200_FFFF, 16'h00FF, 1'b1);
		send_range(32'h0000_0000, 32'h00FF_FFFF, 16'hFF00, 1'b0);
		send_range(32'h0000_0001, 32'hFFFF_FFFE, 16'hFFFF, 1'b1);
		send_range(32'hC0A8_0105, 32'hC0A8_01FA, 16'h0000, 1'b0);
		send_range(32'hC0A8_0100, 32'hC0A8_01FE, 16'h0F0F, 1'b1);
		send_range(32'h0000_0000, 32'h0000_00FE, 16'hF0F0, 1'b0);
		send_range(32'hFF00_0000, 32'hFFFF_FFFF, 16'h3C3C, 1'b1);
		settle();

		// write to an unmapped word is dropped
		write_reg(SpareAddr, 32'hFFFF_FFFF);
		read_max_range();

		write_reg(MaxRangeAddr, 32'd1);
		read_max_range();
		send_range(32'h0A00_0001, 32'h0A00_0001, 16'h1111, 1'b0);
		send_range(32'h0A00_0001, 32'h0A00_0002, 16'h2222, 1'b1);
		send_range(32'h0A00_0009, 32'h0A00_0002, 16'h3333, 1'b0);
		send_random_ranges(30);
		settle();

		write_reg(MaxRangeAddr, 32'hFFFF_FFFF);
		read_max_range();
		send_range(32'h0000_0000, 32'hFFFF_FFFF, 16'h4444, 1'b1);
		send_range(32'h0000_0000, 32'hFFFF_FFFE, 16'h5555, 1'b0);
		send_range(32'h0000_0001, 32'hFFFF_FFFF, 16'h6666, 1'b1);
		send_random_ranges(30);
		settle();

		write_reg(MaxRangeAddr, $urandom_range(32'h0100_0000, 256));
		read_max_range();
		send_random_ranges(80);
		settle();

		write_reg(MaxRangeAddr, 32'd0);
		read_max_range();
		send_random_ranges(40);
		hold_req = ~hold_req;
		send_random_ranges(40);
		send_random_ranges(40);
		settle();
		send_random_ranges(30);
		idle_on = 1'b0;
		send_random_ranges(100);
		idle_on = 1'b1;
		send_random_ranges(50);
		settle();

		if (sb.mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: ip_range_to_octet_blocks.f
+incdir+hw/rtl
hw/rtl/iprob_pkg.sv
hw/rtl/iprob_in_if.sv
hw/rtl/iprob_out_if.sv
hw/rtl/iprob_octet_stage.sv
hw/rtl/ip_range_to_octet_blocks.sv
verif/ip_range_to_octet_blocks_tb.sv
